>>> design/ipv4hb_pkg.sv
package ipv4hb_pkg;

  localparam int ADDR_W      = 32;
  localparam int PROTO_W     = 8;
  localparam int PLEN_W      = 11;
  localparam int TTL_W       = 8;
  localparam int WORD_W      = 32;
  localparam int IDX_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int NUM_WORDS   = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAX_PAYLOAD_DEFAULT = 1480;

  localparam logic [31:0]        SRC_RESET  = 32'h0A00_020F;
  localparam logic [TTL_W-1:0]   TTL_RESET  = 8'd64;
  localparam logic [15:0]        VER_IHL    = 16'h4500;
  localparam logic [15:0]        DF_FLAG    = 16'h4000;
  localparam logic [15:0]        HDR_BYTES  = 16'd20;
  localparam logic [IDX_W-1:0]   LAST_INDEX = IDX_W'(NUM_WORDS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_TO_LIVE   = 1'd1;

  typedef struct packed {
    logic [ADDR_W-1:0]  dest_address;
    logic [PROTO_W-1:0] protocol_number;
    logic [PLEN_W-1:0]  payload_length;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] header_word;
    logic [IDX_W-1:0]  word_index;
    logic              last_word;
    logic              length_error;
  } hdr_t;

  typedef struct packed {
    logic [15:0]        total_length;
    logic [TTL_W-1:0]   ttl;
    logic [PROTO_W-1:0] proto;
    logic [15:0]        checksum;
    logic [ADDR_W-1:0]  src;
    logic [ADDR_W-1:0]  dst;
    logic               err;
  } entry_t;

endpackage

>>> design/ipv4hb_front.sv
module ipv4hb_front
  import ipv4hb_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  req_t               req,
  input  logic [ADDR_W-1:0]  source_address,
  input  logic [TTL_W-1:0]   time_to_live,
  output logic               push,
  input  logic               q_full,
  output entry_t             push_data
);

  localparam logic [PLEN_W-1:0] MAX_PLEN = PLEN_W'(MAX_PAYLOAD);

  logic               s1_valid;
  logic [15:0]        s1_total;
  logic [TTL_W-1:0]   s1_ttl;
  logic [PROTO_W-1:0] s1_proto;
  logic [ADDR_W-1:0]  s1_src;
  logic [ADDR_W-1:0]  s1_dst;
  logic               s1_err;
  logic [17:0]        s1_sum_a;
  logic [17:0]        s1_sum_b;

  logic        accept;
  logic [15:0] total_next;
  logic [18:0] sum;
  logic [16:0] fold1;
  logic [15:0] fold2;

  assign req_stall  = s1_valid && q_full;
  assign accept     = req_valid && !req_stall;
  assign push       = s1_valid && !q_full;
  assign total_next = HDR_BYTES + 16'(req.payload_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_total <= total_next;
      s1_ttl   <= time_to_live;
      s1_proto <= req.protocol_number;
      s1_src   <= source_address;
      s1_dst   <= req.dest_address;
      s1_err   <= req.payload_length > MAX_PLEN;
      s1_sum_a <= 18'(VER_IHL) + 18'(total_next) + 18'(DF_FLAG)
                + 18'({time_to_live, req.protocol_number});
      s1_sum_b <= 18'(source_address[31:16]) + 18'(source_address[15:0])
                + 18'(req.dest_address[31:16]) + 18'(req.dest_address[15:0]);
    end
  end

  // end-around carry, two passes cover the widest sum
  assign sum   = 19'(s1_sum_a) + 19'(s1_sum_b);
  assign fold1 = 17'(sum[15:0]) + 17'(sum[18:16]);
  assign fold2 = fold1[15:0] + 16'(fold1[16]);

  always_comb begin
    push_data.total_length = s1_total;
    push_data.ttl          = s1_ttl;
    push_data.proto        = s1_proto;
    push_data.checksum     = ~fold2;
    push_data.src          = s1_src;
    push_data.dst          = s1_dst;
    push_data.err          = s1_err;
  end

endmodule

>>> design/ipv4hb_queue.sv
module ipv4hb_queue
  import ipv4hb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  output logic   q_valid,
  input  logic   pop,
  output entry_t q_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full    = count == CNT_W'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop)) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

>>> design/ipv4hb_back.sv
module ipv4hb_back
  import ipv4hb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   q_valid,
  input  entry_t q_data,
  output logic   pop,
  output logic   hdr_valid,
  input  logic   hdr_stall,
  output hdr_t   hdr
);

  entry_t           cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;

  logic              out_ready;
  logic              emit;
  logic [WORD_W-1:0] word;

  assign out_ready = !hdr_valid || !hdr_stall;
  assign emit      = out_ready && cur_valid;
  assign pop       = q_valid && (!cur_valid || (emit && idx == LAST_INDEX));

  always_comb begin
    case (idx)
      3'd0:    word = {VER_IHL[15:8], 8'h00, cur.total_length};
      3'd1:    word = {16'h0000, DF_FLAG};
      3'd2:    word = {cur.ttl, cur.proto, cur.checksum};
      3'd3:    word = cur.src;
      3'd4:    word = cur.dst;
      default: word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      hdr_valid <= 1'b0;
    end else begin
      if (emit) begin
        hdr_valid <= 1'b1;
      end else if (out_ready) begin
        hdr_valid <= 1'b0;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (emit) begin
        if (idx == LAST_INDEX) begin
          cur_valid <= 1'b0;
          idx       <= '0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
    if (pop) begin
      cur <= q_data;
    end
    if (emit) begin
      hdr.header_word  <= word;
      hdr.word_index   <= idx;
      hdr.last_word    <= idx == LAST_INDEX;
      hdr.length_error <= cur.err;
    end
  end

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    hdr_valid |-> (hdr.last_word == (hdr.word_index == LAST_INDEX)))
    else $error("last_word does not match word_index");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> idx <= LAST_INDEX) else $error("word counter out of range");

  a_words_follow: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && !hdr_stall && !hdr.last_word |=>
      hdr_valid && hdr.word_index == $past(hdr.word_index) + 1'b1)
    else $error("header words not contiguous");

endmodule

>>> design/ipv4_header_builder.sv
// IPv4 header builder. Each request word (destination, protocol, payload
// length) produces five 32-bit header words, network order, word_index 0..4,
// last_word on the fifth, length_error on all five when the payload exceeds
// MAX_PAYLOAD. The header checksum is computed in the front stage as
// requests arrive; a two-entry queue feeds the back end, which sends one
// header word per cycle unless hdr_stall holds it, via a registered output.
// A new request can be accepted while earlier headers are still being sent;
// it passes front stage registers, queue, current entry, output register.
// source_address and time_to_live are sampled when a request is accepted.
module ipv4_header_builder
  import ipv4hb_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req,
  output logic                 hdr_valid,
  input  logic                 hdr_stall,
  output hdr_t                 hdr,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [ADDR_W-1:0] source_address;
  logic [TTL_W-1:0]  time_to_live;

  logic   push;
  logic   q_full;
  entry_t push_data;
  logic   q_valid;
  logic   pop;
  entry_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_address <= SRC_RESET;
      time_to_live   <= TTL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_ADDRESS: source_address <= cfg_data;
        REG_TIME_TO_LIVE:   time_to_live   <= cfg_data[TTL_W-1:0];
        default: ;
      endcase
    end
  end

  ipv4hb_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req            (req),
    .source_address (source_address),
    .time_to_live   (time_to_live),
    .push           (push),
    .q_full         (q_full),
    .push_data      (push_data)
  );

  ipv4hb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .q_valid   (q_valid),
    .pop       (pop),
    .q_data    (q_data)
  );

  ipv4hb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .hdr_valid (hdr_valid),
    .hdr_stall (hdr_stall),
    .hdr       (hdr)
  );

endmodule

>>> tb/ipv4_header_builder_test.sv
`timescale 1ns / 100ps

module ipv4_header_builder_test;
  import ipv4hb_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 6;
  localparam int SEGMENTS     = 6;
  localparam int SEG_ITEMS    = 58;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT  = 3000;
  localparam int PRINT_CAP    = 60;

  typedef enum logic [1:0] {ROW_REQ, ROW_SRC, ROW_TTL} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    req_t        rq;
    logic [31:0] value;
    logic        typed;
    logic [31:0] word0;
    logic        err;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req = '0;
  logic                 hdr_valid;
  logic                 hdr_stall = 1'b0;
  hdr_t                 hdr;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  logic [ADDR_W-1:0] cur_src = SRC_RESET;
  logic [TTL_W-1:0]  cur_ttl = TTL_RESET;

  hdr_t header_due [$];
  row_t plan [$];

  int send_idle_pct = 24;
  int recv_idle_pct = 73;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int errors = 0;
  int items_sent = 0;
  int words_seen = 0;
  int oversize_items = 0;
  int reg_writes = 0;
  int quiet_cycles = 0;

  ipv4_header_builder dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .hdr_valid (hdr_valid),
    .hdr_stall (hdr_stall),
    .hdr       (hdr),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Full header for a request, returns word k.
  function automatic hdr_t header_word_for(input req_t r, input int k);
    logic [31:0] w [NUM_WORDS];
    logic [15:0] total;
    int unsigned sum;
    hdr_t o;
    total = HDR_BYTES + 16'(r.payload_length);
    w[0] = {VER_IHL, total};
    w[1] = {16'h0000, DF_FLAG};
    w[2] = {cur_ttl, r.protocol_number, 16'h0000};
    w[3] = cur_src;
    w[4] = r.dest_address;
    sum = 0;
    for (int i = 0; i < NUM_WORDS; i++) begin
      sum += w[i][31:16];
      sum += w[i][15:0];
    end
    while ((sum >> 16) != 0)
      sum = (sum & 32'h0000_FFFF) + (sum >> 16);
    w[2][15:0] = ~sum[15:0];
    o.header_word  = w[k];
    o.word_index   = IDX_W'(k);
    o.last_word    = (k == NUM_WORDS - 1);
    o.length_error = (r.payload_length > MAX_PAYLOAD_DEFAULT);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
  endtask

  task automatic check_word(input hdr_t got, input hdr_t want);
    if (got.header_word !== want.header_word)
      report_mismatch("header_word", got.header_word, want.header_word);
    if (got.word_index !== want.word_index)
      report_mismatch("word_index", 32'(got.word_index), 32'(want.word_index));
    if (got.last_word !== want.last_word)
      report_mismatch("last_word", 32'(got.last_word), 32'(want.last_word));
    if (got.length_error !== want.length_error)
      report_mismatch("length_error", 32'(got.length_error), 32'(want.length_error));
  endtask

  function automatic void add_row(input row_kind_e kind, input logic [31:0] dest,
                                  input logic [7:0] proto, input logic [10:0] plen,
                                  input logic [31:0] value, input logic typed,
                                  input logic [31:0] word0, input logic err);
    row_t r;
    r.kind  = kind;
    r.rq    = '{dest_address: dest, protocol_number: proto, payload_length: plen};
    r.value = value;
    r.typed = typed;
    r.word0 = word0;
    r.err   = err;
    plan.push_back(r);
  endfunction

  // Entered at a falling edge with req_valid not yet driven in this step.
  task automatic send_req(input req_t r, input logic typed, input logic [31:0] word0,
                          input logic err);
    hdr_t e;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    for (int k = 0; k < NUM_WORDS; k++) begin
      e = header_word_for(r, k);
      if (typed) begin
        if (k == 0) e.header_word = word0;
        e.length_error = err;
      end
      header_due.push_back(e);
    end
    items_sent++;
    if (r.payload_length > MAX_PAYLOAD_DEFAULT) oversize_items++;
    @(negedge clk);
  endtask

  task automatic settle_idle();
    req_valid <= 1'b0;
    while (header_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SOURCE_ADDRESS: cur_src = data;
      REG_TIME_TO_LIVE:   cur_ttl = data[TTL_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      hdr_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hdr_stall <= 1'b1;
      hold_left--;
    end else if (holds_done < holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      hdr_stall <= 1'b1;
    end else begin
      hdr_stall <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && hdr_valid && !hdr_stall) begin
      words_seen++;
      if (header_due.size() == 0)
        report_mismatch("unexpected word", hdr.header_word, 32'h0);
      else
        check_word(hdr, header_due.pop_front());
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (hdr_valid && !hdr_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", quiet_cycles);
      $display("ipv4_header_builder test failed");
      $finish;
    end
  end

  initial begin
    req_t        r;
    logic [31:0] src_pick;
    logic [7:0]  ttl_pick;

    // reset registers
    add_row(ROW_REQ, 32'h0000_0000, 8'h00, 11'd0,    '0, 1'b1, 32'h4500_0014, 1'b0);
    add_row(ROW_REQ, 32'hFFFF_FFFF, 8'hFF, 11'd2047, '0, 1'b1, 32'h4500_0813, 1'b1);
    add_row(ROW_REQ, 32'hC0A8_0001, 8'd1,  11'd1480, '0, 1'b1, 32'h4500_05DC, 1'b0);
    add_row(ROW_REQ, 32'hC0A8_0001, 8'd1,  11'd1481, '0, 1'b1, 32'h4500_05DD, 1'b1);
    add_row(ROW_REQ, 32'h0808_0808, 8'd6,  11'd40,   '0, 1'b0, '0, 1'b0);
    add_row(ROW_REQ, 32'h7F00_0001, 8'd17, 11'd8,    '0, 1'b0, '0, 1'b0);
    add_row(ROW_REQ, 32'h1234_5678, 8'h80, 11'h555,  '0, 1'b0, '0, 1'b0);
    // low extremes
    add_row(ROW_SRC, '0, '0, '0, 32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(ROW_TTL, '0, '0, '0, 32'h0000_0000, 1'b0, '0, 1'b0);
    add_row(ROW_REQ, 32'h0000_0000, 8'h00, 11'd0,    '0, 1'b1, 32'h4500_0014, 1'b0);
    add_row(ROW_REQ, 32'hFFFF_FFFF, 8'hFF, 11'd2047, '0, 1'b1, 32'h4500_0813, 1'b1);
    // high extremes
    add_row(ROW_SRC, '0, '0, '0, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    add_row(ROW_TTL, '0, '0, '0, 32'h0000_00FF, 1'b0, '0, 1'b0);
    add_row(ROW_REQ, 32'hFFFF_FFFF, 8'hFF, 11'd2047, '0, 1'b1, 32'h4500_0813, 1'b1);
    add_row(ROW_REQ, 32'h0000_0000, 8'h00, 11'd0,    '0, 1'b1, 32'h4500_0014, 1'b0);
    add_row(ROW_REQ, 32'hAAAA_AAAA, 8'h55, 11'h2AA,  '0, 1'b0, '0, 1'b0);
    add_row(ROW_REQ, 32'h5555_5555, 8'hAA, 11'h555,  '0, 1'b0, '0, 1'b0);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_REQ: send_req(plan[i].rq, plan[i].typed, plan[i].word0, plan[i].err);
        ROW_SRC: begin
          settle_idle();
          write_reg(REG_SOURCE_ADDRESS, plan[i].value);
        end
        ROW_TTL: begin
          settle_idle();
          write_reg(REG_TIME_TO_LIVE, plan[i].value);
        end
        default: ;
      endcase
    end

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle_idle();
      case (seg)
        2:       begin src_pick = 32'h0000_0000; ttl_pick = 8'h00; end
        3:       begin src_pick = 32'hFFFF_FFFF; ttl_pick = 8'hFF; end
        default: begin src_pick = $urandom; ttl_pick = 8'($urandom); end
      endcase
      write_reg(REG_SOURCE_ADDRESS, src_pick);
      write_reg(REG_TIME_TO_LIVE, 32'(ttl_pick));
      if (seg == 2) begin
        send_idle_pct = 73;
        recv_idle_pct = 24;
      end
      if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holds_asked++;
      end
      for (int n = 0; n < SEG_ITEMS; n++) begin
        r.dest_address = $urandom;
        case ($urandom_range(0, 3))
          0:       r.protocol_number = 8'd1;
          1:       r.protocol_number = 8'd17;
          default: r.protocol_number = 8'($urandom);
        endcase
        case ($urandom_range(0, 9))
          6, 7:    r.payload_length = 11'($urandom_range(MAX_PAYLOAD_DEFAULT + 1, 2047));
          8:       r.payload_length = 11'($urandom_range(MAX_PAYLOAD_DEFAULT - 1,
                                                         MAX_PAYLOAD_DEFAULT + 1));
          9:       r.payload_length = ($urandom_range(0, 1) == 0) ? 11'd0 : 11'd2047;
          default: r.payload_length = 11'($urandom_range(0, MAX_PAYLOAD_DEFAULT));
        endcase
        send_req(r, 1'b0, '0, 1'b0);
      end
    end

    settle_idle();
    if (header_due.size() != 0)
      report_mismatch("words left over", 32'(header_due.size()), 32'h0);

    $display("%0d requests (%0d oversized), %0d header words, %0d register writes",
             items_sent, oversize_items, words_seen, reg_writes);
    $display("reset, zero and all-ones registers; sender and receiver throttling, long hold");
    if (errors == 0) begin
      $display("ipv4_header_builder test passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("ipv4_header_builder test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/ipv4hb_pkg.sv
design/ipv4hb_front.sv
design/ipv4hb_queue.sv
design/ipv4hb_back.sv
design/ipv4_header_builder.sv
tb/ipv4_header_builder_test.sv
